// ===== src/dms_pkg.sv =====
package dms_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_TARGETS = 8;
    localparam int RESULT_CAP  = 16;
    localparam int MASK_W      = 8;

    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TIDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int TCNT_W = $clog2(MAX_TARGETS + 1);
    localparam int KCNT_W = $clog2(RESULT_CAP + 1);

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 104;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SEND     = 3'd1;
    localparam logic [2:0] CMD_FORCE    = 3'd2;
    localparam logic [2:0] CMD_FLUSH    = 3'd3;
    localparam logic [2:0] CMD_REGISTER = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    localparam logic [1:0] DK_SINGLE = 2'd0;
    localparam logic [1:0] DK_GROUP  = 2'd1;
    localparam logic [1:0] DK_ALL    = 2'd2;

    localparam logic [2:0] RK_DELIVERY   = 3'd0;
    localparam logic [2:0] RK_QUEUED     = 3'd1;
    localparam logic [2:0] RK_REGISTERED = 3'd2;
    localparam logic [2:0] RK_TABLE_FULL = 3'd3;
    localparam logic [2:0] RK_QUEUE_FULL = 3'd4;

    typedef logic [7:0] group_t [MAX_TARGETS];

    typedef struct packed {
        logic [2:0]        kind;
        logic [MASK_W-1:0] mask;
        logic [7:0]        src;
        logic [15:0]       code;
        logic [31:0]       data_a;
        logic [31:0]       data_b;
        logic [2:0]        slot;
    } res_t;

endpackage

// ===== src/dms_reach.sv =====
module dms_reach (
    input  logic [1:0]                 dest_kind,
    input  logic [7:0]                 dest,
    input  logic [dms_pkg::TCNT_W-1:0] target_count,
    input  dms_pkg::group_t            target_group,
    output logic [dms_pkg::MASK_W-1:0] mask
);
    import dms_pkg::*;

    localparam int NM = (MAX_TARGETS < MASK_W) ? MAX_TARGETS : MASK_W;

    always_comb
    begin
        mask = '0;
        case (dest_kind)
            DK_SINGLE:
            begin
                for (int t = 0; t < NM; t++)
                begin
                    if (dest == 8'(t) && TCNT_W'(t) < target_count)
                        mask[t] = 1'b1;
                end
            end
            DK_GROUP:
            begin
                for (int t = 0; t < NM; t++)
                begin
                    if (TCNT_W'(t) < target_count && target_group[t] == dest)
                        mask[t] = 1'b1;
                end
            end
            DK_ALL:
            begin
                for (int t = 0; t < NM; t++)
                begin
                    if (TCNT_W'(t) < target_count)
                        mask[t] = 1'b1;
                end
            end
            default: mask = '0;
        endcase
    end
endmodule

// ===== src/delayed_message_scheduler.sv =====
// Channel  Dir  Fields
// s_*      in   tuser: cmd; tdata: commands and message contents
// m_*      out  tuser: result kind; tdata: delivery or status; tlast: last result
//
// Send, register, clear: do the work at the accepting edge; send and register
// then hand their result to the output register once it is free; clear gives none.
// Tick, force, flush: each queued entry goes in turn through the shared scan
// step, then a finish step; a delivering scan step stalls while the output
// register is full and cannot take the held result.
// One result is held back so tlast can be set on the final one of a command.
// Reset empties the queue and the target table; no clearing pass.
// s_tready is high only when no command is in progress.
module delayed_message_scheduler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cmd[2:0]
    input  logic [2:0]                         s_tuser,
    // dest_kind[1:0], source[9:2], dest[17:10], any_sender[18],
    // message_code[34:19], delay[50:35], data_a[82:51], data_b[114:83]
    input  logic [dms_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // kind[2:0]
    output logic [2:0]                         m_tuser,
    // target_mask[7:0], out_source[15:8], out_code[31:16],
    // out_data_a[63:32], out_data_b[95:64], slot[98:96]
    output logic [dms_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import dms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched command
    logic [2:0]  cmd_reg, cmd_next;
    logic [1:0]  dk_reg, dk_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  dst_reg, dst_next;
    logic        any_reg, any_next;

    // queue storage
    logic [1:0]  qk_reg [QUEUE_DEPTH];
    logic [7:0]  qs_reg [QUEUE_DEPTH];
    logic [7:0]  qd_reg [QUEUE_DEPTH];
    logic [15:0] qc_reg [QUEUE_DEPTH];
    logic [15:0] ql_reg [QUEUE_DEPTH];
    logic [31:0] qa_reg [QUEUE_DEPTH];
    logic [31:0] qb_reg [QUEUE_DEPTH];
    logic [1:0]  qk_next [QUEUE_DEPTH];
    logic [7:0]  qs_next [QUEUE_DEPTH];
    logic [7:0]  qd_next [QUEUE_DEPTH];
    logic [15:0] qc_next [QUEUE_DEPTH];
    logic [15:0] ql_next [QUEUE_DEPTH];
    logic [31:0] qa_next [QUEUE_DEPTH];
    logic [31:0] qb_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;

    // target table
    group_t tg_reg, tg_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;

    // scan sequencer
    logic [QCNT_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] wr_reg, wr_next;
    logic [KCNT_W-1:0] k_reg, k_next;

    // held-back result and output register
    res_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    res_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic out_last_reg, out_last_next;

    // input fields
    logic [1:0]  in_dk;
    logic [7:0]  in_src, in_dst;
    logic        in_any;
    logic [15:0] in_code, in_delay;
    logic [31:0] in_a, in_b;

    assign in_dk    = s_tdata[1:0];
    assign in_src   = s_tdata[9:2];
    assign in_dst   = s_tdata[17:10];
    assign in_any   = s_tdata[18];
    assign in_code  = s_tdata[34:19];
    assign in_delay = s_tdata[50:35];
    assign in_a     = s_tdata[82:51];
    assign in_b     = s_tdata[114:83];

    logic [QIDX_W-1:0] ri, wi;
    assign ri = rd_reg[QIDX_W-1:0];
    assign wi = wr_reg[QIDX_W-1:0];

    // shared reach unit: the incoming message when idle, else the scanned entry
    logic [1:0]        rch_kind;
    logic [7:0]        rch_dest;
    logic [MASK_W-1:0] rch_mask;

    assign rch_kind = (state_reg == ST_IDLE) ? in_dk  : qk_reg[ri];
    assign rch_dest = (state_reg == ST_IDLE) ? in_dst : qd_reg[ri];

    dms_reach u_reach (
        .dest_kind    (rch_kind),
        .dest         (rch_dest),
        .target_count (tcnt_reg),
        .target_group (tg_reg),
        .mask         (rch_mask)
    );

    logic can_emit;
    assign can_emit = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    logic [15:0] dec_delay;
    logic        hit, deliver, drop;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        dk_next         = dk_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        any_next        = any_reg;
        qk_next         = qk_reg;
        qs_next         = qs_reg;
        qd_next         = qd_reg;
        qc_next         = qc_reg;
        ql_next         = ql_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        qcnt_next       = qcnt_reg;
        tg_next         = tg_reg;
        tcnt_next       = tcnt_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        dec_delay = (ql_reg[ri] != 16'd0) ? ql_reg[ri] - 16'd1 : 16'd0;
        hit = (qk_reg[ri] == dk_reg) && (qd_reg[ri] == dst_reg)
              && (any_reg || qs_reg[ri] == src_reg);
        deliver = 1'b0;
        drop    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = s_tuser;
                    dk_next   = in_dk;
                    src_next  = in_src;
                    dst_next  = in_dst;
                    any_next  = in_any;
                    rd_next   = '0;
                    wr_next   = '0;
                    k_next    = '0;
                    state_next = ST_FIN;
                    case (s_tuser)
                        CMD_TICK, CMD_FORCE, CMD_FLUSH: state_next = ST_SCAN;
                        CMD_SEND:
                        begin
                            pend_valid_next = 1'b1;
                            pend_next = '{kind: RK_DELIVERY, mask: rch_mask, src: in_src,
                                          code: in_code, data_a: in_a, data_b: in_b,
                                          slot: 3'd0};
                            if (in_delay != 16'd0)
                            begin
                                pend_next.mask = '0;
                                if (qcnt_reg >= QCNT_W'(QUEUE_DEPTH))
                                begin
                                    pend_next.kind = RK_QUEUE_FULL;
                                end
                                else
                                begin
                                    pend_next.kind = RK_QUEUED;
                                    qk_next[qcnt_reg[QIDX_W-1:0]] = in_dk;
                                    qs_next[qcnt_reg[QIDX_W-1:0]] = in_src;
                                    qd_next[qcnt_reg[QIDX_W-1:0]] = in_dst;
                                    qc_next[qcnt_reg[QIDX_W-1:0]] = in_code;
                                    ql_next[qcnt_reg[QIDX_W-1:0]] = in_delay;
                                    qa_next[qcnt_reg[QIDX_W-1:0]] = in_a;
                                    qb_next[qcnt_reg[QIDX_W-1:0]] = in_b;
                                    qcnt_next = qcnt_reg + QCNT_W'(1);
                                end
                            end
                        end
                        CMD_REGISTER:
                        begin
                            pend_valid_next = 1'b1;
                            pend_next = '0;
                            if (tcnt_reg >= TCNT_W'(MAX_TARGETS))
                            begin
                                pend_next.kind = RK_TABLE_FULL;
                            end
                            else
                            begin
                                pend_next.kind = RK_REGISTERED;
                                pend_next.slot = 3'(tcnt_reg);
                                tg_next[tcnt_reg[TIDX_W-1:0]] = in_dst;
                                tcnt_next = tcnt_reg + TCNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            qcnt_next = '0;
                            tcnt_next = '0;
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_reg == qcnt_reg)
                begin
                    qcnt_next  = wr_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_TICK:  deliver = (dec_delay == 16'd0)
                                             && (k_reg < KCNT_W'(RESULT_CAP));
                        CMD_FORCE: deliver = hit && (k_reg < KCNT_W'(RESULT_CAP));
                        CMD_FLUSH: drop = hit;
                        default:   drop = 1'b0;
                    endcase
                    // stall while the held result cannot move out
                    if (!(deliver && pend_valid_reg && !can_emit))
                    begin
                        if (deliver)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_next       = pend_reg;
                                out_last_next  = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_next = '{kind: RK_DELIVERY, mask: rch_mask,
                                          src: qs_reg[ri], code: qc_reg[ri],
                                          data_a: qa_reg[ri], data_b: qb_reg[ri],
                                          slot: 3'd0};
                            k_next = k_reg + KCNT_W'(1);
                        end
                        else if (!drop)
                        begin
                            // compact kept entries toward the head
                            qk_next[wi] = qk_reg[ri];
                            qs_next[wi] = qs_reg[ri];
                            qd_next[wi] = qd_reg[ri];
                            qc_next[wi] = qc_reg[ri];
                            ql_next[wi] = (cmd_reg == CMD_TICK) ? dec_delay : ql_reg[ri];
                            qa_next[wi] = qa_reg[ri];
                            qb_next[wi] = qb_reg[ri];
                            wr_next = wr_reg + QCNT_W'(1);
                        end
                        rd_next = rd_reg + QCNT_W'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_emit)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            qcnt_reg       <= '0;
            tcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            qcnt_reg       <= qcnt_next;
            tcnt_reg       <= tcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        dk_reg       <= dk_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        any_reg      <= any_next;
        qk_reg       <= qk_next;
        qs_reg       <= qs_next;
        qd_reg       <= qd_next;
        qc_reg       <= qc_next;
        ql_reg       <= ql_next;
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        tg_reg       <= tg_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_reg.slot, out_reg.data_b, out_reg.data_a,
                       out_reg.code, out_reg.src, out_reg.mask};

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left over in idle");
    a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg && rd_reg <= qcnt_reg))
        else $error("scan write index passed read index");
    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KCNT_W'(RESULT_CAP))
        else $error("result budget exceeded");

endmodule
